### hdl/aes_pkg.sv
package aes_pkg;

    localparam int NR = 14;
    localparam int NK = 8;
    localparam int NWORDS = 60;
    localparam int WORD_AW = 6;

    localparam logic [1:0] REG_KEY0 = 2'd0;
    localparam logic [1:0] REG_KEY1 = 2'd1;
    localparam logic [1:0] REG_KEY2 = 2'd2;
    localparam logic [1:0] REG_KEY3 = 2'd3;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [63:0] block_upper;
        logic [63:0] block_lower;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_upper;
        logic [63:0] result_lower;
    } out_item_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    localparam logic [7:0] RCON [7] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40};

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [127:0] o;
        logic [7:0]   a0, a1, a2, a3;
        for (int i = 0; i < 16; i++)
        begin
            b[i] = s[127 - 8 * i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                t[c * 4 + r] = SBOX[b[((c + r) % 4) * 4 + r]];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[c * 4];
            a1 = t[c * 4 + 1];
            a2 = t[c * 4 + 2];
            a3 = t[c * 4 + 3];
            if (last)
            begin
                o[127 - 32 * c -: 32] = {a0, a1, a2, a3};
            end
            else
            begin
                o[127 - 32 * c -: 32] = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                                         a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                                         a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                                         xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
            end
        end
        return o;
    endfunction

    function automatic logic [31:0] inv_mix(input logic [31:0] w);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int r = 0; r < 4; r++)
        begin
            a[r]  = w[31 - 8 * r -: 8];
            x2[r] = xt(a[r]);
            x4[r] = xt(x2[r]);
            x8[r] = xt(x4[r]);
            m9[r] = x8[r] ^ a[r];
            mb[r] = x8[r] ^ x2[r] ^ a[r];
            md[r] = x8[r] ^ x4[r] ^ a[r];
            me[r] = x8[r] ^ x4[r] ^ x2[r];
        end
        return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                m9[0] ^ me[1] ^ mb[2] ^ md[3],
                md[0] ^ m9[1] ^ me[2] ^ mb[3],
                mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

    function automatic logic [127:0] dec_pre(input logic [127:0] s);
        logic [7:0]   b [16];
        logic [127:0] o;
        for (int i = 0; i < 16; i++)
        begin
            b[i] = s[127 - 8 * i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                o[127 - 8 * (c * 4 + r) -: 8] = INV_SBOX[b[((c + 3 * r) % 4) * 4 + r]];
            end
        end
        return o;
    endfunction

endpackage

### hdl/aes_ram.sv
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/aes256_block_cipher.sv
// With the schedule current, a started block alternates a round-key fetch (S_RKEY), reading
// the schedule RAM one word a cycle, and a round step (S_ROUND), over 15 key additions.
// After a key change the first block also loads the 8 key words and expands the other 52.
// A new block is taken only once the last one is through; busy stays high meanwhile.
// The receiver cannot stall; each result shows for one cycle under done.
// Reset (rst_n, asynchronous, low) clears the key to zero and marks the schedule stale.
module aes256_block_cipher #(
    parameter int NWORDS = aes_pkg::NWORDS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  aes_pkg::in_item_t  in_item,
    output logic               done,
    output aes_pkg::out_item_t out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [63:0]        cfg_data
);

    localparam int AW = $clog2(NWORDS);

    typedef enum logic [2:0] {S_IDLE, S_KLOAD, S_KEXP, S_RKEY, S_ROUND, S_DONE} state_t;

    state_t        state_reg;
    logic [255:0]  key_reg;
    logic          ready_reg;
    logic [AW-1:0] cnt_reg;
    logic [1:0]    col_reg;
    logic [3:0]    rnd_reg;
    logic          op_reg;
    logic [127:0]  st_reg;
    logic [127:0]  rk_reg;
    logic [255:0]  win_reg;
    logic [2:0]    sub_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic [AW-1:0] raddr;
    logic [31:0]   rdata;
    logic [31:0]   kt;
    logic [31:0]   knew;
    logic [127:0]  mixed;
    logic [127:0]  rk_full;
    logic [127:0]  xored;

    aes_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);

    // The last eight schedule words slide through a window; the oldest is word i-8.
    always_comb
    begin
        kt = win_reg[31:0];
        if (cnt_reg[2:0] == 3'd0)
        begin
            kt = aes_pkg::sub_word({kt[23:0], kt[31:24]})
                 ^ {aes_pkg::RCON[cnt_reg[AW-1:3] - 3'd1], 24'h0};
        end
        else if (cnt_reg[2:0] == 3'd4)
        begin
            kt = aes_pkg::sub_word(kt);
        end
        knew = win_reg[255:224] ^ kt;
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = cnt_reg;
        wdata = knew;
        if (state_reg == S_KLOAD)
        begin
            we    = 1'b1;
            wdata = key_reg[255 - 32 * cnt_reg[2:0] -: 32];
        end
        else if (state_reg == S_KEXP)
        begin
            we = 1'b1;
        end
        raddr = AW'({rnd_reg, col_reg});
    end

    assign rk_full = {rk_reg[95:0], rdata};
    assign xored   = st_reg ^ rk_reg;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            mixed[127 - 32 * c -: 32] = aes_pkg::inv_mix(xored[127 - 32 * c -: 32]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            key_reg   <= '0;
            ready_reg <= 1'b0;
            cnt_reg   <= '0;
            col_reg   <= '0;
            rnd_reg   <= '0;
            sub_reg   <= '0;
            op_reg    <= 1'b0;
            st_reg    <= '0;
            rk_reg    <= '0;
            win_reg   <= '0;
            out_item  <= '0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid)
                    begin
                        key_reg[255 - 64 * cfg_index -: 64] <= cfg_data;
                        ready_reg <= 1'b0;
                    end
                    if (start)
                    begin
                        op_reg  <= in_item.opcode;
                        st_reg  <= {in_item.block_upper, in_item.block_lower};
                        cnt_reg <= '0;
                        rnd_reg <= in_item.opcode ? 4'(aes_pkg::NR) : 4'd0;
                        col_reg <= 2'd0;
                        sub_reg <= 3'd0;
                        state_reg <= (ready_reg && !cfg_valid) ? S_RKEY : S_KLOAD;
                    end
                end
                S_KLOAD:
                begin
                    win_reg <= {win_reg[223:0], key_reg[255 - 32 * cnt_reg[2:0] -: 32]};
                    cnt_reg <= cnt_reg + AW'(1);
                    if (cnt_reg == AW'(aes_pkg::NK - 1))
                    begin
                        state_reg <= S_KEXP;
                    end
                end
                S_KEXP:
                begin
                    win_reg <= {win_reg[223:0], knew};
                    cnt_reg <= cnt_reg + AW'(1);
                    if (cnt_reg == AW'(NWORDS - 1))
                    begin
                        ready_reg <= 1'b1;
                        state_reg <= S_RKEY;
                    end
                end
                S_RKEY:
                begin
                    // sub_reg counts issued reads; each word returns the cycle after.
                    sub_reg <= sub_reg + 3'd1;
                    col_reg <= col_reg + 2'd1;
                    if (sub_reg != 3'd0)
                    begin
                        rk_reg <= rk_full;
                    end
                    if (sub_reg == 3'd4)
                    begin
                        col_reg <= 2'd0;
                        sub_reg <= 3'd0;
                        state_reg <= S_ROUND;
                    end
                end
                S_ROUND:
                begin
                    if (op_reg == aes_pkg::OP_ENCRYPT)
                    begin
                        if (rnd_reg == 4'(aes_pkg::NR))
                        begin
                            st_reg    <= xored;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            st_reg  <= aes_pkg::enc_round(xored,
                                                          rnd_reg == 4'(aes_pkg::NR - 1));
                            rnd_reg <= rnd_reg + 4'd1;
                            state_reg <= S_RKEY;
                        end
                    end
                    else
                    begin
                        if (rnd_reg == 4'd0)
                        begin
                            st_reg    <= xored;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            if (rnd_reg == 4'(aes_pkg::NR))
                            begin
                                st_reg <= aes_pkg::dec_pre(xored);
                            end
                            else
                            begin
                                st_reg <= aes_pkg::dec_pre(mixed);
                            end
                            rnd_reg <= rnd_reg - 4'd1;
                            state_reg <= S_RKEY;
                        end
                    end
                end
                S_DONE:
                begin
                    done      <= 1'b1;
                    out_item  <= {st_reg[127:64], st_reg[63:0]};
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
